@@ src/dma_request_descriptor_splitter_defines.svh @@
// Assertion macros shared by the descriptor splitter RTL.
`ifndef DMA_REQUEST_DESCRIPTOR_SPLITTER_DEFINES_SVH
`define DMA_REQUEST_DESCRIPTOR_SPLITTER_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define DRDS_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Property that must hold in the cycle after its trigger.
`define DRDS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ src/drds_pkg.sv @@
// Types, constants and codes shared by the descriptor splitter modules.
`default_nettype none
package drds_pkg;

   localparam int RING_DEPTH  = 256;
   localparam int PTR_W       = $clog2(RING_DEPTH);
   localparam int ADDR_W      = 48;
   localparam int BYTES_W     = 22;
   localparam int DATA_W      = 64;
   localparam int LEN_W       = 11;
   localparam int MAX_CHUNKS  = 63;
   localparam int CHUNK_SHIFT = 16;
   localparam int UNIT_SHIFT  = 6;
   localparam int MAX_UNITS   = 1024;
   localparam int CHUNK_W     = BYTES_W + 1 - CHUNK_SHIFT;
   localparam int UNITS_W     = 16;
   localparam int CMP_W       = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] OUTCOME_WRITTEN = 2'd0;
   localparam logic [1:0] OUTCOME_BUSY    = 2'd1;
   localparam logic [1:0] OUTCOME_EMPTY   = 2'd2;

   localparam logic KIND_COPY   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_IRQ    = 2'd1;
   localparam logic [1:0] MODE_NOTIFY = 2'd2;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      logic [1:0]         outcome;
      logic [PTR_W-1:0]   slot;
      logic [PTR_W-1:0]   door;
      logic [CHUNK_W-1:0] chunks;
      logic [UNITS_W-1:0] units;
      logic               has_status;
      logic               notify_mode;
      logic [ADDR_W-1:0]  src;
      logic [ADDR_W-1:0]  dst;
      logic [ADDR_W-1:0]  notify;
      logic [DATA_W-1:0]  data;
   } job_type;

   // Fill status of the job queue.
   typedef struct packed {
      logic not_empty;
      logic full;
   } qstat_type;

   // One result beat.
   typedef struct packed {
      logic [1:0]        outcome;
      logic [PTR_W-1:0]  slot;
      logic              kind;
      logic [ADDR_W-1:0] src_out;
      logic [ADDR_W-1:0] dst_out;
      logic [LEN_W-1:0]  length_units;
      logic              raise_interrupt;
      logic [DATA_W-1:0] status_data;
      logic [PTR_W-1:0]  doorbell_head;
      logic              last;
   } desc_type;

endpackage
`default_nettype wire

@@ src/drds_req_if.sv @@
// Request channel: one copy request per beat.
`default_nettype none
interface drds_req_if;
   logic                                valid;
   logic                                ready;
   logic [drds_pkg::ADDR_W-1:0]         src_addr;
   logic                                src_local;
   logic [drds_pkg::ADDR_W-1:0]         dst_addr;
   logic                                dst_local;
   logic [drds_pkg::BYTES_W-1:0]        byte_count;
   logic [1:0]                          status_mode;
   logic [drds_pkg::ADDR_W-1:0]         notify_addr;
   logic                                notify_local;
   logic [drds_pkg::DATA_W-1:0]         notify_data;
   logic [drds_pkg::PTR_W-1:0]          tail_now;

   modport source (output valid, src_addr, src_local, dst_addr, dst_local, byte_count,
                   status_mode, notify_addr, notify_local, notify_data, tail_now,
                   input ready);
   modport sink (input valid, src_addr, src_local, dst_addr, dst_local, byte_count,
                 status_mode, notify_addr, notify_local, notify_data, tail_now,
                 output ready);
endinterface
`default_nettype wire

@@ src/drds_rsp_if.sv @@
// Result channel: one ring descriptor or status result per beat.
`default_nettype none
interface drds_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    outcome;
   logic [drds_pkg::PTR_W-1:0]    slot;
   logic                          kind;
   logic [drds_pkg::ADDR_W-1:0]   src_out;
   logic [drds_pkg::ADDR_W-1:0]   dst_out;
   logic [drds_pkg::LEN_W-1:0]    length_units;
   logic                          raise_interrupt;
   logic [drds_pkg::DATA_W-1:0]   status_data;
   logic [drds_pkg::PTR_W-1:0]    doorbell_head;
   logic                          last;

   modport source (output valid, outcome, slot, kind, src_out, dst_out, length_units,
                   raise_interrupt, status_data, doorbell_head, last,
                   input ready);
   modport sink (input valid, outcome, slot, kind, src_out, dst_out, length_units,
                 raise_interrupt, status_data, doorbell_head, last,
                 output ready);
endinterface
`default_nettype wire

@@ src/drds_queue.sv @@
// Short job queue between the classifying front and the descriptor back.
`default_nettype none
module drds_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  drds_pkg::job_type   push_job,
   input  wire                 pop,
   output drds_pkg::job_type   pop_job,
   output drds_pkg::qstat_type stat
);

   drds_pkg::job_type               mem_ff [drds_pkg::QUEUE_DEPTH];
   logic [drds_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [drds_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [drds_pkg::QPTR_W:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job        = mem_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != '0);
   assign stat.full      = (count_ff == (drds_pkg::QPTR_W + 1)'(drds_pkg::QUEUE_DEPTH));

endmodule
`default_nettype wire

@@ src/drds_front.sv @@
// Front end: accepts requests, translates addresses and checks ring room.
`default_nettype none
module drds_front (
   input  wire                         clock,
   input  wire                         reset,
   drds_req_if.sink                    req,
   input  wire                         csr_we,
   input  wire [drds_pkg::ADDR_W-1:0]  csr_wdata,
   input  drds_pkg::qstat_type         qstat,
   output logic                        push,
   output drds_pkg::job_type           push_job
);

   logic [drds_pkg::PTR_W-1:0]    head_ff, head_in;
   logic [drds_pkg::PTR_W-1:0]    tail_ff, tail_in;
   logic [drds_pkg::ADDR_W-1:0]   base_ff, base_in;

   logic [drds_pkg::BYTES_W:0]    chunk_sum;
   logic [drds_pkg::BYTES_W:0]    unit_sum;
   logic [drds_pkg::CHUNK_W-1:0]  chunks;
   logic [drds_pkg::CHUNK_W-1:0]  ndesc;
   logic                          has_status;
   logic                          too_many;
   logic [drds_pkg::PTR_W-1:0]    free_cached;
   logic [drds_pkg::PTR_W-1:0]    free_now;
   logic                          fit_cached;
   logic                          fit_now;
   logic                          fits;
   logic                          accept;

   assign req.ready = !qstat.full;
   assign accept    = req.valid && req.ready;

   assign chunk_sum  = {1'b0, req.byte_count}
                       + (drds_pkg::BYTES_W + 1)'((1 << drds_pkg::CHUNK_SHIFT) - 1);
   assign unit_sum   = {1'b0, req.byte_count}
                       + (drds_pkg::BYTES_W + 1)'((1 << drds_pkg::UNIT_SHIFT) - 1);
   assign chunks     = chunk_sum[drds_pkg::BYTES_W:drds_pkg::CHUNK_SHIFT];
   assign has_status = (req.status_mode == drds_pkg::MODE_IRQ)
                       || (req.status_mode == drds_pkg::MODE_NOTIFY);
   assign ndesc      = chunks + drds_pkg::CHUNK_W'(has_status);
   assign too_many   = (chunks > drds_pkg::CHUNK_W'(drds_pkg::MAX_CHUNKS));

   // Free slots keep one entry open so a full ring never looks empty.
   assign free_cached = tail_ff - head_ff - 1'b1;
   assign free_now    = req.tail_now - head_ff - 1'b1;
   assign fit_cached  = drds_pkg::CMP_W'(ndesc) <= drds_pkg::CMP_W'(free_cached);
   assign fit_now     = drds_pkg::CMP_W'(ndesc) <= drds_pkg::CMP_W'(free_now);
   assign fits        = !too_many && (fit_cached || fit_now);

   always_comb begin
      push_job.slot        = head_ff;
      push_job.door        = head_ff;
      push_job.chunks      = chunks;
      push_job.units       = unit_sum[drds_pkg::UNIT_SHIFT + drds_pkg::UNITS_W - 1 :
                                      drds_pkg::UNIT_SHIFT];
      push_job.has_status  = has_status;
      push_job.notify_mode = (req.status_mode == drds_pkg::MODE_NOTIFY);
      push_job.src         = req.src_local ? req.src_addr : req.src_addr + base_ff;
      push_job.dst         = req.dst_local ? req.dst_addr : req.dst_addr + base_ff;
      push_job.notify      = req.notify_local ? req.notify_addr : req.notify_addr + base_ff;
      push_job.data        = req.notify_data;
      if (!fits) begin
         push_job.outcome = drds_pkg::OUTCOME_BUSY;
      end else if (ndesc == '0) begin
         push_job.outcome = drds_pkg::OUTCOME_EMPTY;
      end else begin
         push_job.outcome = drds_pkg::OUTCOME_WRITTEN;
         push_job.door    = head_ff + drds_pkg::PTR_W'(ndesc);
      end
   end

   assign push = accept;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      base_in = base_ff;
      if (csr_we) begin
         base_in = csr_wdata;
      end
      if (accept) begin
         // The reported tail is only picked up when the cached one is too old.
         if (!too_many && !fit_cached) begin
            tail_in = req.tail_now;
         end
         head_in = push_job.door;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         base_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         base_ff <= base_in;
      end
   end

endmodule
`default_nettype wire

@@ src/drds_back.sv @@
// Back end: expands one queued job into result beats, one per cycle unless the output stalls.
`default_nettype none
module drds_back (
   input  wire                 clock,
   input  wire                 reset,
   input  drds_pkg::qstat_type qstat,
   input  drds_pkg::job_type   job,
   output logic                pop,
   drds_rsp_if.source          rsp
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_COPY   = 2'd1;
   localparam logic [1:0] ST_STAT   = 2'd2;
   localparam logic [1:0] ST_SINGLE = 2'd3;

   localparam logic [drds_pkg::ADDR_W-1:0] CHUNK_STEP =
      drds_pkg::ADDR_W'(1) << drds_pkg::CHUNK_SHIFT;

   logic [1:0]                    state_ff, state_in;
   logic [1:0]                    outcome_ff, outcome_in;
   logic [drds_pkg::PTR_W-1:0]    slot_ff, slot_in;
   logic [drds_pkg::PTR_W-1:0]    door_ff, door_in;
   logic [drds_pkg::CHUNK_W-1:0]  left_ff, left_in;
   logic [drds_pkg::UNITS_W-1:0]  units_ff, units_in;
   logic                          stat_ff, stat_in;
   logic                          notify_ff, notify_in;
   logic [drds_pkg::ADDR_W-1:0]   src_ff, src_in;
   logic [drds_pkg::ADDR_W-1:0]   dst_ff, dst_in;
   logic [drds_pkg::ADDR_W-1:0]   naddr_ff, naddr_in;
   logic [drds_pkg::DATA_W-1:0]   data_ff, data_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   drds_pkg::desc_type            rsp_ff, rsp_in;
   drds_pkg::desc_type            desc;
   logic                          emit;
   logic                          advance;
   logic                          big;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign big     = units_ff > drds_pkg::UNITS_W'(drds_pkg::MAX_UNITS);

   always_comb begin
      state_in   = state_ff;
      outcome_in = outcome_ff;
      slot_in    = slot_ff;
      door_in    = door_ff;
      left_in    = left_ff;
      units_in   = units_ff;
      stat_in    = stat_ff;
      notify_in  = notify_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      naddr_in   = naddr_ff;
      data_in    = data_ff;
      pop        = 1'b0;
      emit       = 1'b0;
      desc               = '0;
      desc.slot          = slot_ff;
      desc.doorbell_head = door_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (qstat.not_empty) begin
               pop        = 1'b1;
               outcome_in = job.outcome;
               slot_in    = job.slot;
               door_in    = job.door;
               left_in    = job.chunks;
               units_in   = job.units;
               stat_in    = job.has_status;
               notify_in  = job.notify_mode;
               src_in     = job.src;
               dst_in     = job.dst;
               naddr_in   = job.notify;
               data_in    = job.data;
               if (job.outcome != drds_pkg::OUTCOME_WRITTEN) begin
                  state_in = ST_SINGLE;
               end else if (job.chunks != '0) begin
                  state_in = ST_COPY;
               end else begin
                  state_in = ST_STAT;
               end
            end
         end
         ST_SINGLE: begin
            desc.outcome = outcome_ff;
            desc.last    = 1'b1;
            if (advance) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            desc.outcome      = drds_pkg::OUTCOME_WRITTEN;
            desc.kind         = drds_pkg::KIND_COPY;
            desc.src_out      = src_ff;
            desc.dst_out      = dst_ff;
            desc.length_units = big ? drds_pkg::LEN_W'(drds_pkg::MAX_UNITS)
                                    : drds_pkg::LEN_W'(units_ff);
            desc.last         = (left_ff == drds_pkg::CHUNK_W'(1)) && !stat_ff;
            if (advance) begin
               emit    = 1'b1;
               src_in  = src_ff + CHUNK_STEP;
               dst_in  = dst_ff + CHUNK_STEP;
               slot_in = slot_ff + 1'b1;
               left_in = left_ff - 1'b1;
               if (big) begin
                  units_in = units_ff - drds_pkg::UNITS_W'(drds_pkg::MAX_UNITS);
               end
               if (left_ff == drds_pkg::CHUNK_W'(1)) begin
                  state_in = stat_ff ? ST_STAT : ST_IDLE;
               end
            end
         end
         ST_STAT: begin
            desc.outcome         = drds_pkg::OUTCOME_WRITTEN;
            desc.kind            = drds_pkg::KIND_STATUS;
            desc.raise_interrupt = !notify_ff;
            desc.dst_out         = notify_ff ? naddr_ff : '0;
            desc.status_data     = notify_ff ? data_ff : '0;
            desc.last            = 1'b1;
            if (advance) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = desc;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      outcome_ff <= outcome_in;
      slot_ff    <= slot_in;
      door_ff    <= door_in;
      left_ff    <= left_in;
      units_ff   <= units_in;
      stat_ff    <= stat_in;
      notify_ff  <= notify_in;
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      naddr_ff   <= naddr_in;
      data_ff    <= data_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.outcome         = rsp_ff.outcome;
   assign rsp.slot            = rsp_ff.slot;
   assign rsp.kind            = rsp_ff.kind;
   assign rsp.src_out         = rsp_ff.src_out;
   assign rsp.dst_out         = rsp_ff.dst_out;
   assign rsp.length_units    = rsp_ff.length_units;
   assign rsp.raise_interrupt = rsp_ff.raise_interrupt;
   assign rsp.status_data     = rsp_ff.status_data;
   assign rsp.doorbell_head   = rsp_ff.doorbell_head;
   assign rsp.last            = rsp_ff.last;

endmodule
`default_nettype wire

@@ src/dma_request_descriptor_splitter.sv @@
// Top level of the DMA request descriptor splitter with its result checks.
//
// The splitter turns each copy request into descriptors for a 256-entry DMA ring.
// The byte count is cut into 64 KiB chunks, and each chunk becomes one copy
// descriptor whose length is given in 64-byte units. An optional status descriptor
// follows, which either raises an interrupt or writes a 64-bit value to a notify
// address. Addresses not flagged local get the system base added, modulo 2^48.
// The block tracks the ring head and a cached consumer tail. When the cached tail
// shows too little room, the tail reported with the request is loaded and room is
// checked once more. If the request still does not fit, or it would need more than
// 63 chunks, a single busy beat is returned and the head stays put. A request with
// no bytes and no status descriptor returns a single "accepted, nothing written"
// beat. Every beat carries the head value to publish after its request, and the
// final beat of each request has last set. Timing: the front end classifies a
// request and reserves ring room in the cycle it is accepted. It then parks the
// request in a two-entry queue. The back end picks up a queued request, then emits
// one result beat per cycle unless the output stalls; a request yields at most 64
// beats. The output register and the back end set the sustained rate. The front
// end keeps accepting while the queue has room, even while results are stalled.
// The system base register is written through csr_we and csr_wdata; the user must
// write it only while the block is idle, which the block does not enforce itself.
`default_nettype none
`include "dma_request_descriptor_splitter_defines.svh"
module dma_request_descriptor_splitter (
   input  wire                         clock,
   input  wire                         reset,
   drds_req_if.sink                    req_chan,
   drds_rsp_if.source                  rsp_chan,
   input  wire                         csr_we,
   input  wire [drds_pkg::ADDR_W-1:0]  csr_wdata
);

   // Handoff between the front and back through the job queue.
   logic                 q_push;
   logic                 q_pop;
   drds_pkg::job_type    q_push_job;
   drds_pkg::job_type    q_pop_job;
   drds_pkg::qstat_type  q_stat;

   // The front end owns the head pointer, the cached tail and the system base.
   // It decides each request's outcome at acceptance, so the back end never
   // needs to look at ring state.
   drds_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .qstat     (q_stat),
      .push      (q_push),
      .push_job  (q_push_job)
   );

   drds_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .pop_job  (q_pop_job),
      .stat     (q_stat)
   );

   // The back end walks the chunks, stepping both addresses by 64 KiB and the
   // slot by one for each copy beat, and appends any status descriptor.
   drds_back u_back (
      .clock (clock),
      .reset (reset),
      .qstat (q_stat),
      .job   (q_pop_job),
      .pop   (q_pop),
      .rsp   (rsp_chan)
   );

   // A busy or empty outcome is always a request's only beat.
   `DRDS_ASSERT_IMPLY(a_single_beat_last, clock, reset, rsp_chan.valid && (rsp_chan.outcome != drds_pkg::OUTCOME_WRITTEN), rsp_chan.last, "busy or empty result without last")

   // Status descriptors carry no copy source and no length.
   `DRDS_ASSERT_IMPLY(a_status_clean, clock, reset, rsp_chan.valid && (rsp_chan.kind == drds_pkg::KIND_STATUS), (rsp_chan.length_units == '0) && (rsp_chan.src_out == '0), "status descriptor with copy fields")

   // Every copy chunk holds between one and the maximum number of units.
   `DRDS_ASSERT_IMPLY(a_chunk_length, clock, reset, rsp_chan.valid && (rsp_chan.outcome == drds_pkg::OUTCOME_WRITTEN) && (rsp_chan.kind == drds_pkg::KIND_COPY), (rsp_chan.length_units != '0) && (rsp_chan.length_units <= drds_pkg::LEN_W'(drds_pkg::MAX_UNITS)), "copy chunk length out of range")

   // Once a request has started, its beats follow without gaps.
   `DRDS_ASSERT_NEXT(a_no_gap, clock, reset, rsp_chan.valid && rsp_chan.ready && !rsp_chan.last, rsp_chan.valid, "gap inside a request's result beats")

endmodule
`default_nettype wire
